/* rtl/averaged_temperature_power_monitor_defines.svh */
// ----------------------------------------------------------------------------
// Averaged temperature and power monitor: assertion macros
// Shared property wrappers for the checker; clocked, reset disabled.
// ----------------------------------------------------------------------------
`ifndef AVERAGED_TEMPERATURE_POWER_MONITOR_DEFINES_SVH
`define AVERAGED_TEMPERATURE_POWER_MONITOR_DEFINES_SVH

// Same-cycle implication
`define ATPM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("atpm: same-cycle check failed");

// Next-cycle implication
`define ATPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("atpm: next-cycle check failed");

`endif

/* rtl/atpm_pkg.sv */
// ----------------------------------------------------------------------------
// atpm_pkg
// Types, constants and helper functions of the averaged temperature monitor.
// ----------------------------------------------------------------------------
package atpm_pkg;

    // Ring depth default
    localparam int ATPM_WINDOW = 5;

    // Field widths
    localparam int CODE_W      = 10;
    localparam int VOLT_W      = 9;
    localparam int TEMP_W      = 10;
    localparam int AVG_W       = 10;
    localparam int DIGIT_W     = 4;
    localparam int PERIOD_W    = 9;
    localparam int PTHR_W      = 9;
    localparam int FTHR_W      = 10;
    localparam int VPROD_W     = 19;   // 1023 * 500
    localparam int TPROD_W     = 20;   // 1023 * 1000
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 10;

    // Scale factors and reciprocals for the display digits
    localparam int VOLT_SCALE = 500;
    localparam int TEMP_SCALE = 1000;
    localparam int HUND_RECIP = 41;    // floor(x*41/4096) = x/100 for x <= 1000
    localparam int TENS_RECIP = 205;   // floor(x*205/2048) = x/10 for x < 100

    // Reset values of the registers
    localparam logic [PERIOD_W-1:0] PERIOD_RST = 9'd300;
    localparam logic [PTHR_W-1:0]   PTHR_RST   = 9'd450;
    localparam logic [FTHR_W-1:0]   FTHR_RST   = 10'd200;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD = 2'd0,
        CFG_PTHR   = 2'd1,
        CFG_FTHR   = 2'd2
    } t_cfg_idx;

    // Change event codes
    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_RISE = 2'd1,
        EV_FALL = 2'd2
    } t_event;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE,
        ST_WRITE,
        ST_READ,
        ST_DIV,
        ST_DIG1,
        ST_DIG2,
        ST_DIG3,
        ST_DIG4,
        ST_ALARM
    } t_state;

    // Result item, first member in the highest bits
    typedef struct packed {
        logic [DIGIT_W-1:0] digit_units;
        logic [DIGIT_W-1:0] digit_tens;
        logic [DIGIT_W-1:0] digit_hundreds;
        logic [AVG_W-1:0]   average_temp;
        t_event             fan_event;
        logic               fans_on;
        t_event             power_event;
        logic               power_fail;
    } t_reading;

    localparam int RESULT_W = $bits(t_reading);

    // floor(x / 1023) for x < 1023 * 1024: quotient of a 2^n - 1 divisor
    function automatic logic [9:0] div1023(input logic [19:0] x);
        logic [20:0] s;
        s = 21'(x) + 21'(x[19:10]) + 21'd1;
        return s[19:10];
    endfunction

endpackage

/* rtl/averaged_temperature_power_monitor.sv */
// ----------------------------------------------------------------------------
// averaged_temperature_power_monitor
// Scales supply and temperature ADC codes per tick, averages temperature over
// a ring memory and reports supply alarm, fan state and display digits.
//
//   Channel   Dir  Handshake                          Carries
//   s_axis    in   i_s_axis_tvalid / o_s_axis_tready  voltage and temperature codes
//   m_axis    out  o_m_axis_tvalid / i_m_axis_tready  alarms, events, average, digits
//   cfg       in   i_cfg_valid / o_cfg_ready          register index and data
//
// A tick without a push goes from scaling straight to the alarm state. A push
// tick walks the ring through the single read port and then the bit-serial
// divider before the digit states.
// Reset is synchronous, active low; the ring holds no reset and is read only
// where written. A stalled output holds its result while the next tick is taken.
// ----------------------------------------------------------------------------
module averaged_temperature_power_monitor
    import atpm_pkg::*;
#(
    parameter int WINDOW = ATPM_WINDOW
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // [9:0] voltage_code, [19:10] temperature_code, [23:20] zero
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // [0] power_fail, [2:1] power_event, [3] fans_on, [5:4] fan_event,
    // [15:6] average_temp, [19:16] digit_hundreds, [23:20] digit_tens,
    // [27:24] digit_units, [31:28] zero
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // register write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int SUM_W = AVG_W + $clog2(WINDOW);

    logic              w_ring_we;
    logic [POS_W-1:0]  w_ring_waddr;
    logic [TEMP_W-1:0] w_ring_wdata;
    logic              w_ring_re;
    logic [POS_W-1:0]  w_ring_raddr;
    logic [TEMP_W-1:0] w_ring_rdata;
    logic              w_div_start;
    logic [SUM_W-1:0]  w_div_dividend;
    logic [CNT_W-1:0]  w_div_divisor;
    logic              w_div_done;
    logic [SUM_W-1:0]  w_div_quotient;
    logic              w_out_free;
    logic              w_res_valid;
    t_reading          w_res;

    logic              r_out_valid;
    t_reading          r_out;

    assign o_cfg_ready = 1'b1;

    atpm_ctrl #(
        .WINDOW (WINDOW),
        .POS_W  (POS_W),
        .CNT_W  (CNT_W),
        .SUM_W  (SUM_W)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_s_axis_tvalid),
        .o_in_ready     (o_s_axis_tready),
        .i_vcode        (i_s_axis_tdata[CODE_W-1:0]),
        .i_tcode        (i_s_axis_tdata[2*CODE_W-1:CODE_W]),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_ring_we      (w_ring_we),
        .o_ring_waddr   (w_ring_waddr),
        .o_ring_wdata   (w_ring_wdata),
        .o_ring_re      (w_ring_re),
        .o_ring_raddr   (w_ring_raddr),
        .i_ring_rdata   (w_ring_rdata),
        .o_div_start    (w_div_start),
        .o_div_dividend (w_div_dividend),
        .o_div_divisor  (w_div_divisor),
        .i_div_done     (w_div_done),
        .i_div_quotient (w_div_quotient),
        .i_out_free     (w_out_free),
        .o_res_valid    (w_res_valid),
        .o_res          (w_res)
    );

    atpm_ring #(
        .DEPTH  (WINDOW),
        .ADDR_W (POS_W)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_ring_we),
        .i_waddr (w_ring_waddr),
        .i_wdata (w_ring_wdata),
        .i_re    (w_ring_re),
        .i_raddr (w_ring_raddr),
        .o_rdata (w_ring_rdata)
    );

    atpm_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_div_quotient)
    );

    // Output register: free when empty or drained in this cycle
    assign w_out_free = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(OUT_TDATA_W - RESULT_W)'(0), r_out};

endmodule

/* rtl/atpm_ring.sv */
// ----------------------------------------------------------------------------
// atpm_ring
// Sample ring storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module atpm_ring
    import atpm_pkg::*;
#(
    parameter int DEPTH  = ATPM_WINDOW,
    parameter int ADDR_W = (ATPM_WINDOW > 1) ? $clog2(ATPM_WINDOW) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [TEMP_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [TEMP_W-1:0] o_rdata
);

    logic [TEMP_W-1:0] r_mem [DEPTH];
    logic [TEMP_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/atpm_div.sv */
// ----------------------------------------------------------------------------
// atpm_div
// Restoring divider, one quotient bit per cycle, for the ring average.
// ----------------------------------------------------------------------------
module atpm_div
    import atpm_pkg::*;
#(
    parameter int DIVIDEND_W = AVG_W + $clog2(ATPM_WINDOW),
    parameter int DIVISOR_W  = $clog2(ATPM_WINDOW + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quotient
);

    localparam int STEP_W = $clog2(DIVIDEND_W);

    logic                  r_busy;
    logic                  r_done;
    logic [STEP_W-1:0]     r_step;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_dvs;
    logic [DIVISOR_W:0]    w_trial;
    logic [DIVISOR_W:0]    w_diff;
    logic                  w_ge;

    // One restoring step
    always_comb begin
        w_trial = {r_rem, r_quo[DIVIDEND_W-1]};
        w_ge    = (w_trial >= {1'b0, r_dvs});
        w_diff  = w_trial - {1'b0, r_dvs};
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(DIVIDEND_W - 1);
            end else if (r_busy) begin
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step - 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVIDEND_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DIVISOR_W-1:0] : w_trial[DIVISOR_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* rtl/atpm_ctrl.sv */
// ----------------------------------------------------------------------------
// atpm_ctrl
// Tick sequencer: scaling, countdown, ring push and sum, digits and alarms.
// ----------------------------------------------------------------------------
module atpm_ctrl
    import atpm_pkg::*;
#(
    parameter int WINDOW = ATPM_WINDOW,
    parameter int POS_W  = (ATPM_WINDOW > 1) ? $clog2(ATPM_WINDOW) : 1,
    parameter int CNT_W  = $clog2(ATPM_WINDOW + 1),
    parameter int SUM_W  = AVG_W + $clog2(ATPM_WINDOW)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input items
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [CODE_W-1:0]     i_vcode,
    input  logic [CODE_W-1:0]     i_tcode,
    // register writes
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // ring memory
    output logic                  o_ring_we,
    output logic [POS_W-1:0]      o_ring_waddr,
    output logic [TEMP_W-1:0]     o_ring_wdata,
    output logic                  o_ring_re,
    output logic [POS_W-1:0]      o_ring_raddr,
    input  logic [TEMP_W-1:0]     i_ring_rdata,
    // divider
    output logic                  o_div_start,
    output logic [SUM_W-1:0]      o_div_dividend,
    output logic [CNT_W-1:0]      o_div_divisor,
    input  logic                  i_div_done,
    input  logic [SUM_W-1:0]      i_div_quotient,
    // result
    input  logic                  i_out_free,
    output logic                  o_res_valid,
    output t_reading              o_res
);

    localparam int HPROD_W = AVG_W + 6;
    localparam int REM_W   = 7;
    localparam int TPRD_W  = REM_W + 8;

    t_state              r_state, n_state;

    // registers
    logic [PERIOD_W-1:0] r_period;
    logic [PTHR_W-1:0]   r_pthr;
    logic [FTHR_W-1:0]   r_fthr;

    // tick state
    logic [PERIOD_W-1:0] r_count;
    logic                r_push;
    logic [POS_W-1:0]    r_pos;
    logic [CNT_W-1:0]    r_cnt;
    logic [CNT_W-1:0]    r_idx;
    logic                r_pend;
    logic [AVG_W-1:0]    r_avg;
    logic [DIGIT_W-1:0]  r_hund;
    logic [DIGIT_W-1:0]  r_tens;
    logic [DIGIT_W-1:0]  r_units;
    logic                r_pflag;
    logic                r_fflag;

    // payload
    logic [VPROD_W-1:0]  r_vprod;
    logic [TPROD_W-1:0]  r_tprod;
    logic [VOLT_W-1:0]   r_volt;
    logic [TEMP_W-1:0]   r_temp;
    logic [SUM_W-1:0]    r_sum;
    logic [REM_W-1:0]    r_rem;

    logic [PERIOD_W-1:0] w_dec;
    logic                w_issue;
    logic                w_fire;
    logic                w_pf;
    logic                w_fo;
    logic [HPROD_W-1:0]  w_hprod;
    logic [AVG_W-1:0]    w_hsub;
    logic [TPRD_W-1:0]   w_tprod;
    logic [REM_W-1:0]    w_tsub;
    logic [AVG_W-1:0]    w_tdiff;
    logic [REM_W-1:0]    w_udiff;
    logic [TEMP_W-1:0]   w_vq;

    // Countdown, read issue, digit arithmetic and alarm compares
    always_comb begin
        w_dec   = r_count - 1'b1;
        w_issue = (r_state == ST_READ) && (r_idx < r_cnt);
        w_hprod = HPROD_W'(r_avg) * HPROD_W'(HUND_RECIP);
        w_hsub  = AVG_W'(r_hund) * AVG_W'(100);
        w_tdiff = r_avg - w_hsub;
        w_tprod = TPRD_W'(r_rem) * TPRD_W'(TENS_RECIP);
        w_tsub  = REM_W'(r_tens) * REM_W'(10);
        w_udiff = r_rem - w_tsub;
        w_vq    = div1023(20'(r_vprod));
        w_pf    = (r_volt < r_pthr);
        w_fo    = (r_avg >= r_fthr);
    end

    // Next state and handshake outputs
    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_div_start = 1'b0;
        o_res_valid = 1'b0;
        w_fire      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = ST_SCALE;
                end
            end
            ST_SCALE: begin
                n_state = r_push ? ST_WRITE : ST_ALARM;
            end
            ST_WRITE: begin
                n_state = ST_READ;
            end
            ST_READ: begin
                if (!w_issue && !r_pend) begin
                    o_div_start = 1'b1;
                    n_state     = ST_DIV;
                end
            end
            ST_DIV: begin
                if (i_div_done) begin
                    n_state = ST_DIG1;
                end
            end
            ST_DIG1: n_state = ST_DIG2;
            ST_DIG2: n_state = ST_DIG3;
            ST_DIG3: n_state = ST_DIG4;
            ST_DIG4: n_state = ST_ALARM;
            ST_ALARM: begin
                o_res_valid = i_out_free;
                if (i_out_free) begin
                    w_fire  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Register writes; an index past the list is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RST;
            r_pthr   <= PTHR_RST;
            r_fthr   <= FTHR_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PERIOD: r_period <= i_cfg_data[PERIOD_W-1:0];
                CFG_PTHR:   r_pthr   <= i_cfg_data[PTHR_W-1:0];
                CFG_FTHR:   r_fthr   <= i_cfg_data[FTHR_W-1:0];
                default:    ;
            endcase
        end
    end

    // Tick state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= PERIOD_RST;
            r_push  <= 1'b0;
            r_pos   <= '0;
            r_cnt   <= '0;
            r_idx   <= '0;
            r_pend  <= 1'b0;
            r_avg   <= '0;
            r_hund  <= '0;
            r_tens  <= '0;
            r_units <= '0;
            r_pflag <= 1'b0;
            r_fflag <= 1'b0;
        end else begin
            r_pend <= w_issue;
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        // countdown wraps modulo 512, reload on zero
                        r_push  <= (w_dec == '0);
                        r_count <= (w_dec == '0) ? r_period : w_dec;
                    end
                end
                ST_WRITE: begin
                    r_pos <= (r_pos == POS_W'(WINDOW - 1)) ? '0 : r_pos + 1'b1;
                    if (r_cnt != CNT_W'(WINDOW)) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    r_idx <= '0;
                end
                ST_READ: begin
                    if (w_issue) begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                ST_DIV: begin
                    if (i_div_done) begin
                        r_avg <= i_div_quotient[AVG_W-1:0];
                    end
                end
                ST_DIG1: r_hund  <= w_hprod[HPROD_W-1 -: DIGIT_W];
                ST_DIG3: r_tens  <= w_tprod[TPRD_W-1 -: DIGIT_W];
                ST_DIG4: r_units <= w_udiff[DIGIT_W-1:0];
                ST_ALARM: begin
                    if (w_fire) begin
                        r_pflag <= w_pf;
                        r_fflag <= w_fo;
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload: products, scaled codes, running sum, remainder
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_in_valid) begin
            r_vprod <= VPROD_W'(i_vcode) * VPROD_W'(VOLT_SCALE);
            r_tprod <= TPROD_W'(i_tcode) * TPROD_W'(TEMP_SCALE);
        end
        if (r_state == ST_SCALE) begin
            r_volt <= w_vq[VOLT_W-1:0];
            r_temp <= div1023(r_tprod);
        end
        if (r_state == ST_WRITE) begin
            r_sum <= '0;
        end else if (r_pend) begin
            r_sum <= r_sum + SUM_W'(i_ring_rdata);
        end
        if (r_state == ST_DIG2) begin
            r_rem <= w_tdiff[REM_W-1:0];
        end
    end

    // Ring access: write is done before any read of the same push
    assign o_ring_we      = (r_state == ST_WRITE);
    assign o_ring_waddr   = r_pos;
    assign o_ring_wdata   = r_temp;
    assign o_ring_re      = w_issue;
    assign o_ring_raddr   = r_idx[POS_W-1:0];

    assign o_div_dividend = r_sum;
    assign o_div_divisor  = r_cnt;

    // Result assembly
    always_comb begin
        o_res.power_fail     = w_pf;
        o_res.power_event    = (w_pf == r_pflag) ? EV_NONE : (w_pf ? EV_RISE : EV_FALL);
        o_res.fans_on        = w_fo;
        o_res.fan_event      = (w_fo == r_fflag) ? EV_NONE : (w_fo ? EV_RISE : EV_FALL);
        o_res.average_temp   = r_avg;
        o_res.digit_hundreds = r_hund;
        o_res.digit_tens     = r_tens;
        o_res.digit_units    = r_units;
    end

endmodule

/* rtl/atpm_chk.sv */
// ----------------------------------------------------------------------------
// atpm_chk
// Port-level checks on the result stream of the monitor, bound to the top.
// ----------------------------------------------------------------------------
`include "averaged_temperature_power_monitor_defines.svh"

module atpm_chk
    import atpm_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_tvalid,
    input logic                   i_tready,
    input logic [OUT_TDATA_W-1:0] i_tdata
);

    t_reading    w_res;
    logic        w_pev_ok;
    logic        w_fev_ok;
    logic [13:0] w_rebuilt;
    logic        w_dig_ok;

    assign w_res = i_tdata[RESULT_W-1:0];

    // Event codes against the new levels, digits against the average
    always_comb begin
        w_pev_ok  = (w_res.power_event == EV_NONE)
                 || ((w_res.power_event == EV_RISE) && w_res.power_fail)
                 || ((w_res.power_event == EV_FALL) && !w_res.power_fail);
        w_fev_ok  = (w_res.fan_event == EV_NONE)
                 || ((w_res.fan_event == EV_RISE) && w_res.fans_on)
                 || ((w_res.fan_event == EV_FALL) && !w_res.fans_on);
        w_rebuilt = 14'(w_res.digit_hundreds) * 14'd100
                  + 14'(w_res.digit_tens) * 14'd10
                  + 14'(w_res.digit_units);
        w_dig_ok  = (w_res.digit_tens <= 4'd9) && (w_res.digit_units <= 4'd9)
                 && (w_rebuilt == 14'(w_res.average_temp));
    end

    // A supply event agrees with the new alarm level
    `ATPM_ASSERT_IMPLY(a_power_event, i_clk, i_rst_n, i_tvalid, w_pev_ok)

    // A fan event agrees with the new fan state
    `ATPM_ASSERT_IMPLY(a_fan_event, i_clk, i_rst_n, i_tvalid, w_fev_ok)

    // Display digits rebuild the average
    `ATPM_ASSERT_IMPLY(a_digits, i_clk, i_rst_n, i_tvalid, w_dig_ok)

    // A stalled result holds until its transfer
    `ATPM_ASSERT_NEXT(a_hold, i_clk, i_rst_n, i_tvalid && !i_tready, i_tvalid && $stable(i_tdata))

endmodule

bind averaged_temperature_power_monitor atpm_chk u_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_tvalid (o_m_axis_tvalid),
    .i_tready (i_m_axis_tready),
    .i_tdata  (o_m_axis_tdata)
);

/* bench/tb_averaged_temperature_power_monitor.sv */
// ----------------------------------------------------------------------------
// tb_averaged_temperature_power_monitor
// Self-checking bench for the averaged temperature and power monitor. Ticks of
// ADC codes go in on the input stream. A scoreboard predicts the alarms, the
// events, the average and the digits of every tick, and checks each output
// transfer field by field. Both streams idle at random, and the registers are
// changed between phases.
// ----------------------------------------------------------------------------
module tb_averaged_temperature_power_monitor;
    import atpm_pkg::*;

    localparam int ADC_FULL = 1023;
    // Index past the register map, writes to it are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    // Prediction of every tick and the queue of readings still owed
    class tick_result_board;
        logic [PERIOD_W-1:0] period;
        logic [PTHR_W-1:0]   pthr;
        logic [FTHR_W-1:0]   fthr;
        logic [PERIOD_W-1:0] countdown;
        logic [TEMP_W-1:0]   ring [ATPM_WINDOW];
        int unsigned         slot;
        int unsigned         filled;
        logic [AVG_W-1:0]    avg;
        logic                alarm;
        logic                fans;
        t_reading            pending_readings [$];
        int unsigned         errors;

        function new();
            period    = PERIOD_RST;
            pthr      = PTHR_RST;
            fthr      = FTHR_RST;
            countdown = PERIOD_RST;
            slot      = 0;
            filled    = 0;
            avg       = '0;
            alarm     = 1'b0;
            fans      = 1'b0;
            errors    = 0;
        endfunction

        function void report(string field, int unsigned got, int unsigned want);
            $display("%0t mismatch in %s: got %0d, expected %0d", $time, field, got, want);
            errors++;
        endfunction

        // Register write, data masked to the register width
        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_PERIOD: period = val[PERIOD_W-1:0];
                CFG_PTHR:   pthr   = val[PTHR_W-1:0];
                CFG_FTHR:   fthr   = val[FTHR_W-1:0];
                default: ;
            endcase
        endfunction

        // One accepted tick: advance the state and queue the reading it gives
        function void note_tick(logic [CODE_W-1:0] vc, logic [CODE_W-1:0] tc);
            int unsigned volt;
            int unsigned temp;
            int unsigned total;
            int unsigned i;
            logic        pf;
            logic        fo;
            t_reading    r;
            volt = (32'(vc) * VOLT_SCALE) / ADC_FULL;
            temp = (32'(tc) * TEMP_SCALE) / ADC_FULL;

            // countdown wraps at its width; reload pushes a sample
            countdown = countdown - 1'b1;
            if (countdown == 0) begin
                countdown  = period;
                ring[slot] = temp[TEMP_W-1:0];
                if (filled < ATPM_WINDOW) filled++;
                total = 0;
                for (i = 0; i < filled; i++) total += ring[i];
                avg  = AVG_W'(total / filled);
                slot = (slot + 1) % ATPM_WINDOW;
            end

            // supply alarm and its change event
            pf = (volt < pthr);
            r.power_fail  = pf;
            r.power_event = (pf == alarm) ? EV_NONE : (pf ? EV_RISE : EV_FALL);
            alarm = pf;

            // fan state on the average
            fo = (avg >= fthr);
            r.fans_on   = fo;
            r.fan_event = (fo == fans) ? EV_NONE : (fo ? EV_RISE : EV_FALL);
            fans = fo;

            r.average_temp   = avg;
            r.digit_hundreds = DIGIT_W'(avg / 100);
            r.digit_tens     = DIGIT_W'((avg % 100) / 10);
            r.digit_units    = DIGIT_W'(avg % 10);
            pending_readings.push_back(r);
        endfunction

        // One output transfer against the oldest prediction
        function void check_reading(logic [OUT_TDATA_W-1:0] word);
            t_reading want;
            t_reading got;
            if (pending_readings.size() == 0) begin
                report("unrequested result", word, 0);
                return;
            end
            want = pending_readings.pop_front();
            got  = t_reading'(word[RESULT_W-1:0]);
            if (got.power_fail != want.power_fail)
                report("power_fail", got.power_fail, want.power_fail);
            if (got.power_event != want.power_event)
                report("power_event", got.power_event, want.power_event);
            if (got.fans_on != want.fans_on)
                report("fans_on", got.fans_on, want.fans_on);
            if (got.fan_event != want.fan_event)
                report("fan_event", got.fan_event, want.fan_event);
            if (got.average_temp != want.average_temp)
                report("average_temp", got.average_temp, want.average_temp);
            if (got.digit_hundreds != want.digit_hundreds)
                report("digit_hundreds", got.digit_hundreds, want.digit_hundreds);
            if (got.digit_tens != want.digit_tens)
                report("digit_tens", got.digit_tens, want.digit_tens);
            if (got.digit_units != want.digit_units)
                report("digit_units", got.digit_units, want.digit_units);
            if (word[OUT_TDATA_W-1:RESULT_W] != '0)
                report("padding", word[OUT_TDATA_W-1:RESULT_W], 0);
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    tick_result_board board;
    logic             steady   = 1'b0;   // no idling on either side
    logic             hold_req = 1'b0;   // asks the receiver for a long stall
    int               temp_level = 512;

    averaged_temperature_power_monitor u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Mostly short gaps, now and then a long one
    function automatic int unsigned idle_gap();
        int unsigned r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // One tick on the input stream; valid stays up when no gap follows
    task automatic send_tick(input logic [CODE_W-1:0] vc, input logic [CODE_W-1:0] tc);
        int unsigned gap;
        gap = idle_gap();
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {4'b0, tc, vc};
        do @(posedge i_clk); while (!o_s_axis_tready);
        board.note_tick(vc, tc);
    endtask

    // Stop offering ticks until every reading has come back
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (board.pending_readings.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_register(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [CFG_DATA_W-1:0] period,
                            input logic [CFG_DATA_W-1:0] pthr,
                            input logic [CFG_DATA_W-1:0] fthr);
        wait_drained();
        write_reg(CFG_PERIOD, period);
        write_reg(CFG_PTHR, pthr);
        write_reg(CFG_FTHR, fthr);
    endtask

    // Random ticks: temperature drifts around a level that jumps now and
    // then, voltage mostly sits close to the supply threshold
    task automatic run_ticks(input int unsigned n);
        int unsigned k;
        int          v;
        int          t;
        int          vb;
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 19) == 0) temp_level = $urandom_range(0, ADC_FULL);
            if ($urandom_range(0, 7) == 0)
                t = $urandom_range(0, ADC_FULL);
            else
                t = temp_level + int'($urandom_range(0, 64)) - 32;
            vb = (int'(board.pthr) * ADC_FULL + VOLT_SCALE - 1) / VOLT_SCALE;
            case ($urandom_range(0, 9))
                0:       v = 0;
                1:       v = ADC_FULL;
                2, 3:    v = $urandom_range(0, ADC_FULL);
                default: v = vb + int'($urandom_range(0, 12)) - 6;
            endcase
            if (t < 0) t = 0;
            if (t > ADC_FULL) t = ADC_FULL;
            if (v < 0) v = 0;
            if (v > ADC_FULL) v = ADC_FULL;
            send_tick(v[CODE_W-1:0], t[CODE_W-1:0]);
        end
    endtask

    // Output side: check transfers, stall at random or on request
    initial begin
        int unsigned stall_left;
        stall_left      = 0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
                board.check_reading(o_m_axis_tdata);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = 400;
            end else if (stall_left == 0 && $urandom_range(0, 3) == 0) begin
                stall_left = idle_gap();
            end
            if (stall_left != 0) begin
                i_m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // Run limit
    initial begin
        #(20 * 1000000);
        $display("CHECKS FAILED");
        $finish;
    end

    // Stimulus
    initial begin
        board           = new();
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = CFG_PERIOD;
        i_cfg_data      = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset registers: code extremes and both sides of 450
        send_tick(10'd0, 10'd0);
        send_tick(10'd1023, 10'd1023);
        send_tick(10'd920, 10'd512);
        send_tick(10'd921, 10'd512);
        send_tick(10'd920, 10'd0);
        send_tick(10'd1023, 10'd1023);

        // masked writes, fans on from a zero average, dropped write
        set_regs(10'h201, 10'h2FA, 10'd0);
        write_reg(CFG_UNMAPPED, 10'h3FF);
        // runs up to the first reload at tick 300
        run_ticks(294);

        // average to full scale, then back to zero through the ring wrap
        wait_drained();
        write_reg(CFG_FTHR, 10'd1000);
        repeat (5) send_tick(10'($urandom), 10'd1023);
        repeat (5) send_tick(10'($urandom), 10'd0);

        // push every tick, output held off long enough to back up the input
        set_regs(10'd1, 10'($urandom_range(100, 400)), 10'($urandom_range(400, 600)));
        hold_req = 1'b1;
        run_ticks(130);

        // no idling; top supply threshold, fan threshold out of reach
        set_regs(10'd3, 10'd500, 10'd1023);
        steady = 1'b1;
        run_ticks(100);
        steady = 1'b0;

        // supply never flagged
        set_regs(10'd2, 10'd0, 10'($urandom_range(300, 700)));
        run_ticks(100);

        // period written as zero through the mask: one push per 512 ticks
        set_regs(10'h200, 10'($urandom_range(100, 450)), 10'($urandom_range(300, 700)));
        run_ticks(520);

        // longest period, supply threshold above the scale
        set_regs(10'd511, 10'd511, 10'($urandom_range(0, 1000)));
        run_ticks(30);

        wait_drained();
        repeat (40) @(posedge i_clk);
        if (board.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
